// File: hdl/acre_pkg.sv
// ----------------------------------------------------------------------------
// acre_pkg
// Shared types, codes and helpers of the command and response engine.
// ----------------------------------------------------------------------------
`default_nettype none

package acre_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = PTR_W + 1;
  localparam int TAG_BITS    = 8;
  localparam int ADDR_W      = 64;
  localparam int CREDIT_W    = 7;
  localparam logic [CREDIT_W-1:0] CREDIT_MAX = 7'd64;

  // event kind, taken straight from the command field
  typedef enum logic [1:0] {
    KIND_ACCEL = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_DRAIN = 2'd2,
    KIND_IDLE  = 2'd3
  } kind_t;

  localparam logic [2:0] CLS_INTR    = 3'd0;
  localparam logic [2:0] CLS_RESTART = 3'd1;
  localparam logic [2:0] CLS_RLOCK   = 3'd2;
  localparam logic [2:0] CLS_READ    = 3'd3;
  localparam logic [2:0] CLS_WUNLOCK = 3'd4;
  localparam logic [2:0] CLS_WRITE   = 3'd5;

  typedef enum logic [1:0] {
    MODE_RUNNING  = 2'd0,
    MODE_FLUSHING = 2'd1,
    MODE_LOCK     = 2'd2,
    MODE_NLOCK    = 2'd3
  } mode_t;

  localparam logic [1:0] CODE_DONE    = 2'd0;
  localparam logic [1:0] CODE_FLUSHED = 2'd1;
  localparam logic [1:0] CODE_AERROR  = 2'd2;
  localparam logic [1:0] CODE_NLOCK   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_NEXT,
    ST_CMD
  } st_t;

  typedef struct packed {
    kind_t               kind;
    logic [TAG_BITS-1:0] tag;
    logic [2:0]          cls;
    logic [ADDR_W-1:0]   addr;
    logic                ok;
  } item_t;

  typedef struct packed {
    logic                resp_valid;
    logic [TAG_BITS-1:0] resp_tag;
    logic [1:0]          resp_code;
    logic                fetch_valid;
    logic [TAG_BITS-1:0] fetch_tag;
    logic [ADDR_W-1:0]   fetch_address;
    logic                supply_valid;
    logic [TAG_BITS-1:0] supply_tag;
    logic [ADDR_W-1:0]   supply_address;
    logic                interrupt;
    logic [CREDIT_W-1:0] credits;
    logic                overflow;
  } res_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [ADDR_W-1:0]   addr;
    logic                unlock;
    logic                ok;
  } wr_ent_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [1:0]          code;
  } rs_ent_t;

  function automatic logic [CREDIT_W-1:0] credit_up(logic [CREDIT_W-1:0] c);
    return (c < CREDIT_MAX) ? c + 7'd1 : c;
  endfunction

  function automatic logic [CREDIT_W-1:0] credit_down(logic [CREDIT_W-1:0] c);
    return (c != '0) ? c - 7'd1 : c;
  endfunction

endpackage

`default_nettype wire

// File: hdl/acre_front.sv
// ----------------------------------------------------------------------------
// acre_front
// Input queue: accepts events, classifies them and holds up to two.
// ----------------------------------------------------------------------------
`default_nettype none

module acre_front (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_push,
  output logic                        in_full,
  input  wire  [1:0]                  in_command,
  input  wire  [acre_pkg::TAG_BITS-1:0] in_tag,
  input  wire  [2:0]                  in_cmd_class,
  input  wire  [acre_pkg::ADDR_W-1:0] in_address,
  input  wire                         in_address_ok,
  output logic                        fe_valid,
  output acre_pkg::item_t             fe_item,
  input  wire                         fe_pop
);

  acre_pkg::item_t ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign in_full  = (cnt_r == 2'd2);
  assign do_push  = in_push && !in_full;
  assign fe_valid = (cnt_r != 2'd0);
  assign do_pop   = fe_pop && fe_valid;
  assign fe_item  = ent_r[rp_r];

  // classify and store an accepted transfer
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r].kind <= acre_pkg::kind_t'(in_command);
      ent_r[wp_r].tag  <= in_tag;
      ent_r[wp_r].cls  <= in_cmd_class;
      ent_r[wp_r].addr <= in_address;
      ent_r[wp_r].ok   <= in_address_ok;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

// File: hdl/acre_res_queue.sv
// ----------------------------------------------------------------------------
// acre_res_queue
// Two-entry result queue between the engine and the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module acre_res_queue (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            res_push,
  input  acre_pkg::res_t res_in,
  output logic           res_room,
  output logic           res_empty,
  output acre_pkg::res_t res_out,
  input  wire            res_pop
);

  acre_pkg::res_t ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_pop;

  assign res_room  = (cnt_r != 2'd2);
  assign res_empty = (cnt_r == 2'd0);
  assign do_pop    = res_pop && !res_empty;
  assign res_out   = ent_r[rp_r];

  // hold a finished result until it is taken
  always_ff @(posedge clk) begin
    if (res_push) ent_r[wp_r] <= res_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (res_push) wp_r <= ~wp_r;
      if (do_pop)   rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(res_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

// File: hdl/acre_engine.sv
// ----------------------------------------------------------------------------
// acre_engine
// Back end: mode, credits, write queue and response queue, one event at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module acre_engine (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             fe_valid,
  input  acre_pkg::item_t fe_item,
  output logic            fe_pop,
  input  wire             res_room,
  output logic            res_push,
  output acre_pkg::res_t  res_out
);

  localparam int PW = acre_pkg::PTR_W;
  localparam int CW = acre_pkg::CNT_W;
  localparam logic [CW-1:0] DEPTH = CW'(acre_pkg::QUEUE_DEPTH);

  acre_pkg::st_t   state_r, state_nxt;
  acre_pkg::mode_t mode_r, mode_nxt;
  logic [acre_pkg::CREDIT_W-1:0] credit_r, credit_nxt, credit_dn;
  logic [PW-1:0] rs_head_r, rs_head_nxt, wr_head_r, wr_head_nxt;
  logic [CW-1:0] rs_cnt_r, rs_cnt_nxt, wr_cnt_r, wr_cnt_nxt, nl_r, nl_nxt;
  acre_pkg::item_t item_r, item_nxt;
  acre_pkg::res_t  res_r, res_nxt;

  // memories
  acre_pkg::rs_ent_t rs_mem [acre_pkg::QUEUE_DEPTH];
  acre_pkg::wr_ent_t wr_mem [acre_pkg::QUEUE_DEPTH];
  acre_pkg::rs_ent_t rs_q;
  acre_pkg::wr_ent_t wr_q;
  logic [PW-1:0] rs_rd_addr, wr_rd_addr, wm_waddr, rm_waddr;
  logic          wm_we, rm_we;
  acre_pkg::wr_ent_t wm_wdata;
  acre_pkg::rs_ent_t rm_wdata;

  logic pop_en, push_en, push_ok, mark, need_next;
  logic [acre_pkg::TAG_BITS-1:0] push_tag;
  logic [1:0] push_code;

  assign credit_dn = acre_pkg::credit_down(credit_r);

  always_ff @(posedge clk) begin
    if (rm_we) rs_mem[rm_waddr] <= rm_wdata;
    rs_q <= rs_mem[rs_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wm_we) wr_mem[wm_waddr] <= wm_wdata;
    wr_q <= wr_mem[wr_rd_addr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      acre_pkg::ST_IDLE: if (fe_pop) state_nxt = acre_pkg::ST_READ;
      acre_pkg::ST_READ: state_nxt = need_next ? acre_pkg::ST_NEXT : acre_pkg::ST_CMD;
      acre_pkg::ST_NEXT: state_nxt = acre_pkg::ST_CMD;
      acre_pkg::ST_CMD:  state_nxt = acre_pkg::ST_IDLE;
      default:           state_nxt = acre_pkg::ST_IDLE;
    endcase
  end

  // datapath and queue control
  always_comb begin
    mode_nxt    = mode_r;
    credit_nxt  = credit_r;
    rs_head_nxt = rs_head_r;
    rs_cnt_nxt  = rs_cnt_r;
    nl_nxt      = nl_r;
    wr_head_nxt = wr_head_r;
    wr_cnt_nxt  = wr_cnt_r;
    item_nxt    = item_r;
    res_nxt     = res_r;
    fe_pop      = 1'b0;
    res_push    = 1'b0;
    need_next   = 1'b0;
    pop_en      = 1'b0;
    push_en     = 1'b0;
    push_ok     = 1'b0;
    push_tag    = '0;
    push_code   = acre_pkg::CODE_DONE;
    mark        = 1'b0;
    wm_we       = 1'b0;
    wm_waddr    = wr_head_r + wr_cnt_r[PW-1:0];
    wm_wdata    = '0;
    wr_rd_addr  = wr_head_r;
    rs_rd_addr  = rs_head_r;
    rm_we       = 1'b0;
    rm_waddr    = rs_head_r + rs_cnt_r[PW-1:0];
    rm_wdata    = '0;

    unique case (state_r)
      // take the next event, start reading both queue heads
      acre_pkg::ST_IDLE: begin
        if (fe_valid && res_room) begin
          fe_pop   = 1'b1;
          item_nxt = fe_item;
          res_nxt  = '0;
        end
      end
      // drain, then flush or complete the head write
      acre_pkg::ST_READ: begin
        if (item_r.kind == acre_pkg::KIND_DRAIN && rs_cnt_r != '0) begin
          pop_en             = 1'b1;
          res_nxt.resp_valid = 1'b1;
          res_nxt.resp_tag   = rs_q.tag;
          res_nxt.resp_code  = (nl_r != '0) ? acre_pkg::CODE_NLOCK : rs_q.code;
        end
        if (item_r.kind != acre_pkg::KIND_IDLE && wr_cnt_r != '0 &&
            mode_r == acre_pkg::MODE_FLUSHING) begin
          push_en     = 1'b1;
          push_tag    = wr_q.tag;
          push_code   = acre_pkg::CODE_FLUSHED;
          wr_head_nxt = wr_head_r + PW'(1);
          wr_cnt_nxt  = wr_cnt_r - CW'(1);
        end else if (item_r.kind == acre_pkg::KIND_DATA && wr_cnt_r != '0) begin
          credit_nxt = acre_pkg::credit_up(credit_r);
          if (wr_q.unlock && (mode_r == acre_pkg::MODE_LOCK ||
                              mode_r == acre_pkg::MODE_NLOCK)) begin
            mode_nxt = acre_pkg::MODE_RUNNING;
          end
          push_en     = 1'b1;
          push_tag    = wr_q.tag;
          push_code   = acre_pkg::CODE_DONE;
          wr_head_nxt = wr_head_r + PW'(1);
          wr_cnt_nxt  = wr_cnt_r - CW'(1);
          if (wr_cnt_r > CW'(1)) begin
            need_next  = 1'b1;
            wr_rd_addr = wr_head_r + PW'(1);
          end
        end
      end
      // issue the new head write
      acre_pkg::ST_NEXT: begin
        if (mode_r != acre_pkg::MODE_FLUSHING) begin
          if (!wr_q.ok) begin
            push_en   = 1'b1;
            push_tag  = wr_q.tag;
            push_code = acre_pkg::CODE_AERROR;
            mode_nxt  = acre_pkg::MODE_FLUSHING;
          end else begin
            res_nxt.fetch_valid   = 1'b1;
            res_nxt.fetch_tag     = wr_q.tag;
            res_nxt.fetch_address = wr_q.addr;
          end
        end
      end
      // accelerator command, then hand over the result
      acre_pkg::ST_CMD: begin
        res_push = 1'b1;
        if (item_r.kind == acre_pkg::KIND_ACCEL) begin
          push_tag = item_r.tag;
          if (mode_r == acre_pkg::MODE_FLUSHING && item_r.cls != acre_pkg::CLS_RESTART) begin
            push_en   = 1'b1;
            push_code = acre_pkg::CODE_FLUSHED;
          end else begin
            credit_nxt = credit_dn;
            if ((mode_r == acre_pkg::MODE_LOCK && item_r.cls != acre_pkg::CLS_WUNLOCK) ||
                mode_r == acre_pkg::MODE_NLOCK) begin
              push_en   = 1'b1;
              push_code = acre_pkg::CODE_NLOCK;
              mode_nxt  = acre_pkg::MODE_NLOCK;
              mark      = 1'b1;
            end else begin
              unique case (item_r.cls)
                acre_pkg::CLS_INTR: begin
                  push_en           = 1'b1;
                  push_code         = acre_pkg::CODE_FLUSHED;
                  res_nxt.interrupt = 1'b1;
                end
                acre_pkg::CLS_RESTART: begin
                  mode_nxt = acre_pkg::MODE_RUNNING;
                  push_en  = 1'b1;
                end
                acre_pkg::CLS_RLOCK, acre_pkg::CLS_READ: begin
                  if (item_r.cls == acre_pkg::CLS_RLOCK) begin
                    mark     = 1'b1;
                    mode_nxt = acre_pkg::MODE_LOCK;
                  end
                  push_en = 1'b1;
                  if (!item_r.ok) begin
                    push_code = acre_pkg::CODE_AERROR;
                    mode_nxt  = acre_pkg::MODE_FLUSHING;
                  end else begin
                    res_nxt.supply_valid   = 1'b1;
                    res_nxt.supply_tag     = item_r.tag;
                    res_nxt.supply_address = item_r.addr;
                    credit_nxt             = acre_pkg::credit_up(credit_dn);
                  end
                end
                acre_pkg::CLS_WUNLOCK, acre_pkg::CLS_WRITE: begin
                  if (wr_cnt_r >= DEPTH) begin
                    push_en    = 1'b1;
                    push_code  = acre_pkg::CODE_FLUSHED;
                    credit_nxt = acre_pkg::credit_up(credit_dn);
                  end else begin
                    if (wr_cnt_r == '0) begin
                      if (!item_r.ok) begin
                        push_en   = 1'b1;
                        push_code = acre_pkg::CODE_AERROR;
                        mode_nxt  = acre_pkg::MODE_FLUSHING;
                      end else begin
                        res_nxt.fetch_valid   = 1'b1;
                        res_nxt.fetch_tag     = item_r.tag;
                        res_nxt.fetch_address = item_r.addr;
                      end
                    end
                    wm_we           = 1'b1;
                    wm_wdata.tag    = item_r.tag;
                    wm_wdata.addr   = item_r.addr;
                    wm_wdata.unlock = (item_r.cls == acre_pkg::CLS_WUNLOCK);
                    wm_wdata.ok     = item_r.ok;
                    wr_cnt_nxt      = wr_cnt_r + CW'(1);
                  end
                end
                default: ;
              endcase
            end
          end
        end
      end
      default: ;
    endcase

    // queue a response, or drop it when the queue is full
    if (push_en) begin
      if ((rs_cnt_r - CW'(pop_en)) >= DEPTH) begin
        res_nxt.overflow = 1'b1;
      end else begin
        push_ok       = 1'b1;
        rm_we         = 1'b1;
        rm_wdata.tag  = push_tag;
        rm_wdata.code = push_code;
      end
    end
    rs_cnt_nxt  = rs_cnt_r - CW'(pop_en) + CW'(push_ok);
    rs_head_nxt = rs_head_r + PW'(pop_en);
    if (pop_en && nl_r != '0) nl_nxt = nl_r - CW'(1);
    // all responses queued so far now answer lock failed
    if (mark) nl_nxt = rs_cnt_r;

    res_out         = res_nxt;
    res_out.credits = credit_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= acre_pkg::ST_IDLE;
      mode_r    <= acre_pkg::MODE_RUNNING;
      credit_r  <= acre_pkg::CREDIT_MAX;
      rs_head_r <= '0;
      rs_cnt_r  <= '0;
      nl_r      <= '0;
      wr_head_r <= '0;
      wr_cnt_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      mode_r    <= mode_nxt;
      credit_r  <= credit_nxt;
      rs_head_r <= rs_head_nxt;
      rs_cnt_r  <= rs_cnt_nxt;
      nl_r      <= nl_nxt;
      wr_head_r <= wr_head_nxt;
      wr_cnt_r  <= wr_cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

endmodule

`default_nettype wire

// File: hdl/accel_cmd_response_engine_unit.sv
// ----------------------------------------------------------------------------
// accel_cmd_response_engine_unit
// Host-side command and response engine with input and result queues.
// ----------------------------------------------------------------------------
// Each event pushed in gives exactly one result: the drained response, any
// write-data fetch or read supply, the interrupt flag, the credit count and
// the overflow flag. Events are handled one at a time by a sequencer that
// passes through a next state only when a write-data return exposes a new
// head write, which needs one more read of the write queue memory; the front
// queue holds two events and the result queue two results, so both sides
// can stall independently. Both 64-entry queues live in memories with one
// write port and one registered read port; a lock marks the queued responses
// by a count, with no sweep, and no clearing pass runs after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_cmd_response_engine_unit (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_push,
  output logic                          in_full,
  input  wire  [1:0]                    in_command,
  input  wire  [acre_pkg::TAG_BITS-1:0] in_tag,
  input  wire  [2:0]                    in_cmd_class,
  input  wire  [acre_pkg::ADDR_W-1:0]   in_address,
  input  wire                           in_address_ok,
  output logic                          out_empty,
  input  wire                           out_pop,
  output logic                          out_resp_valid,
  output logic [acre_pkg::TAG_BITS-1:0] out_resp_tag,
  output logic [1:0]                    out_resp_code,
  output logic                          out_fetch_valid,
  output logic [acre_pkg::TAG_BITS-1:0] out_fetch_tag,
  output logic [acre_pkg::ADDR_W-1:0]   out_fetch_address,
  output logic                          out_supply_valid,
  output logic [acre_pkg::TAG_BITS-1:0] out_supply_tag,
  output logic [acre_pkg::ADDR_W-1:0]   out_supply_address,
  output logic                          out_interrupt,
  output logic [acre_pkg::CREDIT_W-1:0] out_credits,
  output logic                          out_overflow
);

  logic            fe_valid, fe_pop, res_room, res_push;
  acre_pkg::item_t fe_item;
  acre_pkg::res_t  res_in, res_q;

  acre_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_command    (in_command),
    .in_tag        (in_tag),
    .in_cmd_class  (in_cmd_class),
    .in_address    (in_address),
    .in_address_ok (in_address_ok),
    .fe_valid      (fe_valid),
    .fe_item       (fe_item),
    .fe_pop        (fe_pop)
  );

  acre_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .fe_valid (fe_valid),
    .fe_item  (fe_item),
    .fe_pop   (fe_pop),
    .res_room (res_room),
    .res_push (res_push),
    .res_out  (res_in)
  );

  acre_res_queue u_res_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res_in    (res_in),
    .res_room  (res_room),
    .res_empty (out_empty),
    .res_out   (res_q),
    .res_pop   (out_pop)
  );

  // unpack the oldest result onto the ports
  assign out_resp_valid     = res_q.resp_valid;
  assign out_resp_tag       = res_q.resp_tag;
  assign out_resp_code      = res_q.resp_code;
  assign out_fetch_valid    = res_q.fetch_valid;
  assign out_fetch_tag      = res_q.fetch_tag;
  assign out_fetch_address  = res_q.fetch_address;
  assign out_supply_valid   = res_q.supply_valid;
  assign out_supply_tag     = res_q.supply_tag;
  assign out_supply_address = res_q.supply_address;
  assign out_interrupt      = res_q.interrupt;
  assign out_credits        = res_q.credits;
  assign out_overflow       = res_q.overflow;

endmodule

`default_nettype wire

// File: dv/tb_accel_cmd_response_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accel_cmd_response_engine_unit
// Self-checking bench for the command and response engine. A scoreboard class
// tracks mode, credits, the pending-write queue and the response queue, and
// predicts one result per accepted event. Directed events cover the corner
// cases, then random traffic with a burst that fills both queues.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_accel_cmd_response_engine_unit;

  // Tracks engine state and compares results in order
  class engine_scoreboard;
    acre_pkg::mode_t                       mode;
    logic [acre_pkg::CREDIT_W-1:0]         credit_cnt;
    acre_pkg::rs_ent_t                     resp_q[$];
    acre_pkg::wr_ent_t                     write_q[$];
    acre_pkg::res_t                        expected_q[$];
    acre_pkg::res_t                        cur;
    int                                    mismatches;
    int                                    checked;

    function void clear();
      mode = acre_pkg::MODE_RUNNING;
      credit_cnt = acre_pkg::CREDIT_MAX;
      resp_q.delete();
      write_q.delete();
      expected_q.delete();
      mismatches = 0;
      checked = 0;
    endfunction

    function void give_credit();
      if (credit_cnt < acre_pkg::CREDIT_MAX) credit_cnt = credit_cnt + 1'b1;
    endfunction

    function void take_credit();
      if (credit_cnt != '0) credit_cnt = credit_cnt - 1'b1;
    endfunction

    function void queue_resp(logic [acre_pkg::TAG_BITS-1:0] tag, logic [1:0] code);
      acre_pkg::rs_ent_t e;
      if (resp_q.size() >= acre_pkg::QUEUE_DEPTH) begin
        cur.overflow = 1'b1;
        return;
      end
      e.tag = tag;
      e.code = code;
      resp_q.push_back(e);
    endfunction

    function void mark_nlock();
      foreach (resp_q[i]) resp_q[i].code = acre_pkg::CODE_NLOCK;
    endfunction

    function void start_write(logic [acre_pkg::TAG_BITS-1:0] tag,
                              logic [acre_pkg::ADDR_W-1:0] addr, logic ok);
      if (mode == acre_pkg::MODE_FLUSHING) return;
      if (!ok) begin
        queue_resp(tag, acre_pkg::CODE_AERROR);
        mode = acre_pkg::MODE_FLUSHING;
        return;
      end
      cur.fetch_valid = 1'b1;
      cur.fetch_tag = tag;
      cur.fetch_address = addr;
    endfunction

    function void retire_write();
      void'(write_q.pop_front());
      if (write_q.size() != 0)
        start_write(write_q[0].tag, write_q[0].addr, write_q[0].ok);
    endfunction

    function void supply_read(logic [acre_pkg::TAG_BITS-1:0] tag,
                              logic [acre_pkg::ADDR_W-1:0] addr, logic ok);
      if (mode == acre_pkg::MODE_FLUSHING) begin
        queue_resp(tag, acre_pkg::CODE_FLUSHED);
        return;
      end
      if (!ok) begin
        queue_resp(tag, acre_pkg::CODE_AERROR);
        mode = acre_pkg::MODE_FLUSHING;
        return;
      end
      cur.supply_valid = 1'b1;
      cur.supply_tag = tag;
      cur.supply_address = addr;
      give_credit();
      queue_resp(tag, (mode == acre_pkg::MODE_NLOCK) ? acre_pkg::CODE_NLOCK
                                                     : acre_pkg::CODE_DONE);
    endfunction

    function void run_command(logic [acre_pkg::TAG_BITS-1:0] tag, logic [2:0] cls,
                              logic [acre_pkg::ADDR_W-1:0] addr, logic ok);
      acre_pkg::wr_ent_t w;
      if (mode == acre_pkg::MODE_FLUSHING && cls != acre_pkg::CLS_RESTART) begin
        queue_resp(tag, acre_pkg::CODE_FLUSHED);
        return;
      end
      take_credit();
      if ((mode == acre_pkg::MODE_LOCK && cls != acre_pkg::CLS_WUNLOCK) ||
          mode == acre_pkg::MODE_NLOCK) begin
        queue_resp(tag, acre_pkg::CODE_NLOCK);
        mode = acre_pkg::MODE_NLOCK;
        mark_nlock();
        return;
      end
      case (cls)
        acre_pkg::CLS_INTR: queue_resp(tag, acre_pkg::CODE_FLUSHED);
        acre_pkg::CLS_RESTART: begin
          mode = acre_pkg::MODE_RUNNING;
          queue_resp(tag, acre_pkg::CODE_DONE);
        end
        acre_pkg::CLS_RLOCK: begin
          mark_nlock();
          mode = acre_pkg::MODE_LOCK;
          supply_read(tag, addr, ok);
        end
        acre_pkg::CLS_READ: supply_read(tag, addr, ok);
        acre_pkg::CLS_WUNLOCK, acre_pkg::CLS_WRITE: begin
          if (write_q.size() >= acre_pkg::QUEUE_DEPTH) begin
            queue_resp(tag, acre_pkg::CODE_FLUSHED);
            give_credit();
          end else begin
            if (write_q.size() == 0) start_write(tag, addr, ok);
            w.tag = tag;
            w.addr = addr;
            w.unlock = (cls == acre_pkg::CLS_WUNLOCK);
            w.ok = ok;
            write_q.push_back(w);
          end
        end
        default: ;
      endcase
    endfunction

    // Predict the result of one accepted event
    function void note_event(acre_pkg::item_t it);
      cur = '0;
      if (it.kind != acre_pkg::KIND_IDLE) begin
        if (it.kind == acre_pkg::KIND_DRAIN && resp_q.size() != 0) begin
          cur.resp_valid = 1'b1;
          cur.resp_tag = resp_q[0].tag;
          cur.resp_code = resp_q[0].code;
          void'(resp_q.pop_front());
        end
        if (write_q.size() != 0 && mode == acre_pkg::MODE_FLUSHING) begin
          queue_resp(write_q[0].tag, acre_pkg::CODE_FLUSHED);
          retire_write();
        end else if (write_q.size() != 0 && it.kind == acre_pkg::KIND_DATA) begin
          give_credit();
          if (write_q[0].unlock && (mode == acre_pkg::MODE_LOCK ||
                                    mode == acre_pkg::MODE_NLOCK))
            mode = acre_pkg::MODE_RUNNING;
          queue_resp(write_q[0].tag, acre_pkg::CODE_DONE);
          retire_write();
        end
        if (it.kind == acre_pkg::KIND_ACCEL) begin
          if (it.cls == acre_pkg::CLS_INTR && mode == acre_pkg::MODE_RUNNING)
            cur.interrupt = 1'b1;
          run_command(it.tag, it.cls, it.addr, it.ok);
        end
      end
      cur.credits = credit_cnt;
      expected_q.push_back(cur);
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_outcome(acre_pkg::res_t act);
      acre_pkg::res_t exp_r;
      bit             bad;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", act);
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      bad = 0;
      if (act.resp_valid     !== exp_r.resp_valid)     bad = 1;
      if (act.resp_tag       !== exp_r.resp_tag)       bad = 1;
      if (act.resp_code      !== exp_r.resp_code)      bad = 1;
      if (act.fetch_valid    !== exp_r.fetch_valid)    bad = 1;
      if (act.fetch_tag      !== exp_r.fetch_tag)      bad = 1;
      if (act.fetch_address  !== exp_r.fetch_address)  bad = 1;
      if (act.supply_valid   !== exp_r.supply_valid)   bad = 1;
      if (act.supply_tag     !== exp_r.supply_tag)     bad = 1;
      if (act.supply_address !== exp_r.supply_address) bad = 1;
      if (act.interrupt      !== exp_r.interrupt)      bad = 1;
      if (act.credits        !== exp_r.credits)        bad = 1;
      if (act.overflow       !== exp_r.overflow)       bad = 1;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on result %0d\n  expected %p\n  actual   %p",
                   checked, exp_r, act);
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 300000;

  logic                          clk;
  logic                          rst_n;
  logic                          in_push;
  logic                          in_full;
  logic [1:0]                    in_command;
  logic [acre_pkg::TAG_BITS-1:0] in_tag;
  logic [2:0]                    in_cmd_class;
  logic [acre_pkg::ADDR_W-1:0]   in_address;
  logic                          in_address_ok;
  logic                          out_empty;
  logic                          out_pop;
  acre_pkg::res_t                act;

  engine_scoreboard sb;
  bit  no_idle;
  int  cycles;
  int  sent;

  accel_cmd_response_engine_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_command        (in_command),
    .in_tag            (in_tag),
    .in_cmd_class      (in_cmd_class),
    .in_address        (in_address),
    .in_address_ok     (in_address_ok),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_resp_valid    (act.resp_valid),
    .out_resp_tag      (act.resp_tag),
    .out_resp_code     (act.resp_code),
    .out_fetch_valid   (act.fetch_valid),
    .out_fetch_tag     (act.fetch_tag),
    .out_fetch_address (act.fetch_address),
    .out_supply_valid  (act.supply_valid),
    .out_supply_tag    (act.supply_tag),
    .out_supply_address(act.supply_address),
    .out_interrupt     (act.interrupt),
    .out_credits       (act.credits),
    .out_overflow      (act.overflow)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Note each transfer on both sides at the edge
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full)
      sb.note_event('{kind: acre_pkg::kind_t'(in_command), tag: in_tag,
                      cls: in_cmd_class, addr: in_address, ok: in_address_ok});
    if (rst_n && out_pop && !out_empty) sb.check_outcome(act);
  end

  // Stall the result side at random
  always @(posedge clk) begin
    if (!rst_n) out_pop <= 1'b0;
    else out_pop <= no_idle ? 1'b1 : ($urandom_range(99) >= 22);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Hold one event on the input until its transfer
  task automatic send(acre_pkg::item_t it);
    if (!no_idle && $urandom_range(99) < 22) begin
      in_push <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_push       <= 1'b1;
    in_command    <= it.kind;
    in_tag        <= it.tag;
    in_cmd_class  <= it.cls;
    in_address    <= it.addr;
    in_address_ok <= it.ok;
    do @(posedge clk); while (in_full);
    sent++;
  endtask

  function automatic acre_pkg::item_t make_item(acre_pkg::kind_t k, logic [2:0] cls,
                                                logic ok);
    acre_pkg::item_t it;
    logic [31:0]     rnd;
    rnd     = $urandom;
    it.kind = k;
    it.tag  = rnd[acre_pkg::TAG_BITS-1:0];
    it.cls  = cls;
    it.addr = {$urandom, $urandom};
    it.ok   = ok;
    return it;
  endfunction

  function automatic acre_pkg::item_t random_item();
    int              r;
    acre_pkg::kind_t k;
    r = $urandom_range(99);
    if (r < 45) k = acre_pkg::KIND_ACCEL;
    else if (r < 65) k = acre_pkg::KIND_DATA;
    else if (r < 95) k = acre_pkg::KIND_DRAIN;
    else k = acre_pkg::KIND_IDLE;
    return make_item(k, 3'($urandom_range(7)), $urandom_range(99) < 88);
  endfunction

  initial begin
    acre_pkg::item_t it;
    sb = new();
    sb.clear();
    no_idle       = 0;
    cycles        = 0;
    sent          = 0;
    rst_n         = 1'b0;
    in_push       = 1'b0;
    in_command    = acre_pkg::KIND_IDLE;
    in_tag        = '0;
    in_cmd_class  = '0;
    in_address    = '0;
    in_address_ok = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corner cases
    send(make_item(acre_pkg::KIND_DRAIN, acre_pkg::CLS_READ, 1'b1));  // drain while empty
    send(make_item(acre_pkg::KIND_DATA, acre_pkg::CLS_READ, 1'b1));   // data with no write
    send(make_item(acre_pkg::KIND_IDLE, 3'd7, 1'b1));                 // idle event
    it = make_item(acre_pkg::KIND_ACCEL, acre_pkg::CLS_INTR, 1'b1);
    it.tag = '0;
    send(it);                                                         // interrupt
    it = make_item(acre_pkg::KIND_ACCEL, acre_pkg::CLS_READ, 1'b1);
    it.tag = '1;
    it.addr = '1;
    send(it);                                                         // read, top address
    it = make_item(acre_pkg::KIND_ACCEL, acre_pkg::CLS_WRITE, 1'b1);
    it.addr = '0;
    send(it);                                                         // write, fetch issued
    send(make_item(acre_pkg::KIND_ACCEL, acre_pkg::CLS_WRITE, 1'b1)); // second write queued
    send(make_item(acre_pkg::KIND_DATA, acre_pkg::CLS_INTR, 1'b1));   // complete head, next
    send(make_item(acre_pkg::KIND_ACCEL, acre_pkg::CLS_WRITE, 1'b1));
    send(make_item(acre_pkg::KIND_ACCEL, acre_pkg::CLS_READ, 1'b0));  // bad address, flush
    send(make_item(acre_pkg::KIND_ACCEL, acre_pkg::CLS_WRITE, 1'b1)); // write while flushing
    send(make_item(acre_pkg::KIND_ACCEL, acre_pkg::CLS_READ, 1'b1));  // flushed command
    send(make_item(acre_pkg::KIND_DATA, acre_pkg::CLS_READ, 1'b1));   // data while flushing
    send(make_item(acre_pkg::KIND_ACCEL, acre_pkg::CLS_RESTART, 1'b1));
    send(make_item(acre_pkg::KIND_ACCEL, acre_pkg::CLS_WRITE, 1'b0)); // failed write issue
    send(make_item(acre_pkg::KIND_ACCEL, acre_pkg::CLS_RESTART, 1'b1));
    send(make_item(acre_pkg::KIND_ACCEL, acre_pkg::CLS_RLOCK, 1'b1)); // lock
    send(make_item(acre_pkg::KIND_ACCEL, acre_pkg::CLS_WUNLOCK, 1'b1));
    send(make_item(acre_pkg::KIND_ACCEL, acre_pkg::CLS_READ, 1'b1));  // breaks the lock
    send(make_item(acre_pkg::KIND_DATA, acre_pkg::CLS_READ, 1'b1));   // unlock completes
    send(make_item(acre_pkg::KIND_ACCEL, 3'd6, 1'b1));                // other class
    send(make_item(acre_pkg::KIND_ACCEL, 3'd7, 1'b1));                // class seven
    repeat (4) send(make_item(acre_pkg::KIND_DRAIN, acre_pkg::CLS_READ, 1'b1));

    // Random traffic, one stretch with no idling, one queue-filling burst
    for (int n = 0; n < 210; n++) begin
      no_idle = (n >= 60 && n < 140);
      if (n == 150) begin
        send(make_item(acre_pkg::KIND_ACCEL, acre_pkg::CLS_RESTART, 1'b1));
        repeat (70) send(make_item(acre_pkg::KIND_ACCEL, acre_pkg::CLS_WRITE, 1'b1));
        repeat (70) send(make_item(acre_pkg::KIND_ACCEL, acre_pkg::CLS_READ, 1'b1));
        repeat (70) send(make_item(acre_pkg::KIND_DRAIN, acre_pkg::CLS_READ, 1'b1));
      end
      send(random_item());
    end
    in_push <= 1'b0;
    no_idle = 0;

    // Drain and settle
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d events sent, %0d results checked, queues filled past capacity",
             sent, sb.checked);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
